// ===== src/alm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types, codes and constants of the linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int unsigned Slots  = 256;
  localparam int unsigned SlotW  = $clog2(Slots);
  localparam int unsigned ValueW = 32;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [2:0]       mode_t;

  localparam mode_t ModeAfter  = 3'd0;
  localparam mode_t ModeBefore = 3'd1;
  localparam mode_t ModeFront  = 3'd2;
  localparam mode_t ModeBack   = 3'd3;
  localparam mode_t ModeDelete = 3'd4;
  localparam mode_t ModeLocate = 3'd5;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StBad  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LINK,
    S_FIX,
    S_WALK,
    S_STEP,
    S_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic check;
    logic link;
    logic fix;
    logic walk;
    logic step;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic is_loc;
    logic walk_done;
    logic out_free;
  } stat_t;

  // Next link of a slot that was never written: the initial free chain.
  function automatic slot_t next_init(slot_t a);
    slot_t r;
    if (a == slot_t'(0) || a == slot_t'(Slots - 1)) begin
      r = slot_t'(0);
    end else begin
      r = a + slot_t'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/array_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager_core
// Doubly linked list in a 256-slot store with a free list, one request at a time.
// ----------------------------------------------------------------------------
// Usage: each input request carries a mode, a position and a data word. It is
// taken at a clock edge where in_valid_i is high and in_stall_o is low. Every
// request returns exactly one result (slot, status, element count), taken at
// an edge where out_valid_o is high and out_stall_i is low.
// Sequence: one request is processed at a time. An insert or delete passes a check
// phase, a link phase that writes the new or removed slot, and a fix phase that
// updates the neighbors, before its result is loaded. A refused request goes
// from the check phase straight to its final step. A locate of element n walks the
// next-link store from the head: per hop, a walk phase reads the next link on the
// registered read port and a step phase takes it. The input is ready again the
// cycle after the result register is loaded.
// Reset clears the list, chains all slots but the sentinel into the free list
// through per-entry valid bits, and needs no clearing pass.
// A stalled result holds in the output register. The next request can still
// be accepted and processed; it waits at its final step until the register
// empties.
// ----------------------------------------------------------------------------
module array_linked_list_manager_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  mode_i,
  input  alm_pkg::slot_t              position_i,
  input  logic [alm_pkg::ValueW-1:0]  item_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output alm_pkg::slot_t              slot_o,
  output logic [1:0]                  status_o,
  output alm_pkg::slot_t              element_count_o
);

  alm_pkg::cmd_t  cmd;
  alm_pkg::stat_t stat;

  // The controller sequences the phases of each request.
  alm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath owns the stores, the list registers and the result register.
  alm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .out_stall_i     (out_stall_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .slot_o          (slot_o),
    .status_o        (status_o),
    .element_count_o (element_count_o)
  );

`ifndef SYNTHESIS
  // A failed request always reports the sentinel slot.
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != alm_pkg::StOk) |-> (slot_o == '0))
    else $error("failed request returned a nonzero slot");

  // Only one request is in work: acceptance closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // The fix phase always follows the link phase.
  a_link_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link |=> cmd.fix)
    else $error("link phase not followed by fix phase");
`endif

endmodule

// ===== src/alm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_ctrl
// Sequencer of the linked list manager: steps each request through its phases.
// ----------------------------------------------------------------------------
module alm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  alm_pkg::stat_t stat_i,
  output alm_pkg::cmd_t  cmd_o,
  output logic           in_stall_o
);

  alm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      alm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = alm_pkg::S_CHECK;
      end
      alm_pkg::S_CHECK: begin
        if (stat_i.reject) begin
          state_d = alm_pkg::S_FIN;
        end else if (stat_i.is_loc) begin
          state_d = alm_pkg::S_WALK;
        end else begin
          state_d = alm_pkg::S_LINK;
        end
      end
      alm_pkg::S_LINK: state_d = alm_pkg::S_FIX;
      alm_pkg::S_FIX:  state_d = alm_pkg::S_FIN;
      alm_pkg::S_WALK: begin
        state_d = stat_i.walk_done ? alm_pkg::S_FIN : alm_pkg::S_STEP;
      end
      alm_pkg::S_STEP: state_d = alm_pkg::S_WALK;
      alm_pkg::S_FIN: begin
        if (stat_i.out_free) state_d = alm_pkg::S_IDLE;
      end
      default: state_d = alm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      alm_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      alm_pkg::S_CHECK: cmd_o.check = 1'b1;
      alm_pkg::S_LINK:  cmd_o.link  = 1'b1;
      alm_pkg::S_FIX:   cmd_o.fix   = 1'b1;
      alm_pkg::S_WALK:  cmd_o.walk  = 1'b1;
      alm_pkg::S_STEP:  cmd_o.step  = 1'b1;
      alm_pkg::S_FIN:   cmd_o.fin   = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/alm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_dpath
// Link stores, list registers, checks and the result register.
// ----------------------------------------------------------------------------
module alm_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  alm_pkg::cmd_t               cmd_i,
  input  alm_pkg::mode_t              mode_i,
  input  alm_pkg::slot_t              position_i,
  input  logic [alm_pkg::ValueW-1:0]  item_value_i,
  input  logic                        out_stall_i,
  output alm_pkg::stat_t              stat_o,
  output logic                        out_valid_o,
  output alm_pkg::slot_t              slot_o,
  output logic [1:0]                  status_o,
  output alm_pkg::slot_t              element_count_o
);

  // Link and data stores.
  alm_pkg::slot_t             next_mem_q [alm_pkg::Slots];
  alm_pkg::slot_t             prev_mem_q [alm_pkg::Slots];
  logic [alm_pkg::ValueW-1:0] val_mem_q  [alm_pkg::Slots];
  logic [alm_pkg::Slots-1:0]  next_vld_q, free_q;

  // List registers.
  alm_pkg::slot_t head_q, tail_q, free_head_q, count_q;

  // Request and working registers.
  alm_pkg::mode_t             mode_q;
  alm_pkg::slot_t             pos_q, anchor_q, ins_q, nxt_q, prv_q, walk_q, k_q;
  logic [alm_pkg::ValueW-1:0] val_q;
  logic                       hd_hit_q, tl_hit_q;
  alm_pkg::status_e           st_q;
  alm_pkg::slot_t             res_slot_q;

  // Registered read ports.
  alm_pkg::slot_t nxa_q, nxb_q, pv_q, nxa_aq, nxb_aq;
  logic           nxa_vq, nxb_vq;
  logic           tgt_free_q;

  // Output register.
  logic             out_valid_q;
  alm_pkg::slot_t   out_slot_q, out_count_q;
  alm_pkg::status_e out_st_q;

  logic           is_ins, is_del, is_loc, after_cls, anchor_ok, bad, full, out_free;
  alm_pkg::slot_t anchor, tgt, tgt_in, nxa_val, nxb_val, pv_val, nxt_c, prv_c;
  alm_pkg::slot_t nxa_addr;
  logic           nx_we, pv_we;
  alm_pkg::slot_t nx_wa, nx_wd, pv_wa, pv_wd;

  assign is_ins    = (mode_q <= alm_pkg::ModeBack);
  assign is_del    = (mode_q == alm_pkg::ModeDelete);
  assign is_loc    = (mode_q == alm_pkg::ModeLocate);
  assign after_cls = (mode_q == alm_pkg::ModeAfter) || (mode_q == alm_pkg::ModeBack);

  always_comb begin
    case (mode_q)
      alm_pkg::ModeFront: anchor = head_q;
      alm_pkg::ModeBack:  anchor = tail_q;
      default:            anchor = pos_q;
    endcase
  end

  // Slot whose free mark the incoming request checks, read as it is accepted.
  always_comb begin
    case (mode_i)
      alm_pkg::ModeFront: tgt_in = head_q;
      alm_pkg::ModeBack:  tgt_in = tail_q;
      default:            tgt_in = position_i;
    endcase
  end

  assign anchor_ok = (anchor == '0) ? (count_q == '0) : !tgt_free_q;
  assign tgt       = is_del ? pos_q : anchor;

  always_comb begin
    bad = 1'b0;
    if (is_ins) begin
      bad = !anchor_ok;
    end else if (is_del) begin
      bad = (pos_q == '0) || tgt_free_q;
    end else if (is_loc) begin
      bad = (pos_q == '0) || (pos_q > count_q);
    end else begin
      bad = 1'b1;
    end
  end

  assign full     = is_ins && (free_head_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.reject    = bad || full;
  assign stat_o.is_loc    = is_loc;
  assign stat_o.walk_done = (k_q == pos_q);
  assign stat_o.out_free  = out_free;

  // Next links never written read as their reset values. Prev links are only
  // read for slots in the list, which have always been written.
  assign nxa_val = nxa_vq ? nxa_q : alm_pkg::next_init(nxa_aq);
  assign nxb_val = nxb_vq ? nxb_q : alm_pkg::next_init(nxb_aq);
  assign pv_val  = pv_q;

  always_comb begin
    if (is_del) begin
      nxt_c = nxa_val;
      prv_c = pv_val;
    end else if (after_cls) begin
      nxt_c = (anchor_q == '0) ? '0 : nxa_val;
      prv_c = anchor_q;
    end else begin
      nxt_c = anchor_q;
      prv_c = (anchor_q == '0) ? '0 : pv_val;
    end
  end

  assign nxa_addr = cmd_i.walk ? walk_q : tgt;

  // Write ports: the slot itself in the link phase, its neighbors in the fix phase.
  always_comb begin
    nx_we = 1'b0;
    pv_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    pv_wa = '0;
    pv_wd = '0;
    if (cmd_i.link) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      nx_wa = is_del ? pos_q : ins_q;
      pv_wa = nx_wa;
      nx_wd = is_del ? free_head_q : nxt_c;
      pv_wd = is_del ? '0 : prv_c;
    end else if (cmd_i.fix) begin
      nx_wa = prv_q;
      pv_wa = nxt_q;
      if (is_del) begin
        nx_we = !hd_hit_q && (prv_q != '0);
        pv_we = !tl_hit_q && (nxt_q != '0);
        nx_wd = nxt_q;
        pv_wd = prv_q;
      end else begin
        nx_we = (prv_q != '0);
        pv_we = (nxt_q != '0);
        nx_wd = ins_q;
        pv_wd = ins_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem_q[nx_wa] <= nx_wd;
    if (pv_we) prev_mem_q[pv_wa] <= pv_wd;
    if (cmd_i.link && !is_del) val_mem_q[ins_q] <= val_q;
    nxa_q  <= next_mem_q[nxa_addr];
    nxb_q  <= next_mem_q[free_head_q];
    pv_q   <= prev_mem_q[tgt];
    nxa_aq <= nxa_addr;
    nxb_aq <= free_head_q;
    nxa_vq <= next_vld_q[nxa_addr];
    nxb_vq <= next_vld_q[free_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q  <= '0;
      free_q      <= {{(alm_pkg::Slots-1){1'b1}}, 1'b0};
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= alm_pkg::slot_t'(1);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (nx_we) next_vld_q[nx_wa] <= 1'b1;
      if (cmd_i.link) begin
        if (is_del) begin
          if (head_q == pos_q) head_q <= nxt_c;
          if (tail_q == pos_q) tail_q <= prv_c;
          free_head_q    <= pos_q;
          free_q[pos_q]  <= 1'b1;
          count_q        <= count_q - alm_pkg::slot_t'(1);
        end else begin
          if (prv_c == '0) head_q <= ins_q;
          if (nxt_c == '0) tail_q <= ins_q;
          free_head_q    <= nxb_val;
          free_q[ins_q]  <= 1'b0;
          count_q        <= count_q + alm_pkg::slot_t'(1);
        end
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q     <= mode_i;
      pos_q      <= position_i;
      val_q      <= item_value_i;
      tgt_free_q <= free_q[tgt_in];
    end
    if (cmd_i.check) begin
      anchor_q <= anchor;
      ins_q    <= free_head_q;
      walk_q   <= head_q;
      k_q      <= alm_pkg::slot_t'(1);
      if (bad) begin
        st_q       <= alm_pkg::StBad;
        res_slot_q <= '0;
      end else if (full) begin
        st_q       <= alm_pkg::StFull;
        res_slot_q <= '0;
      end else begin
        st_q       <= alm_pkg::StOk;
        res_slot_q <= is_del ? pos_q : free_head_q;
      end
    end
    if (cmd_i.link) begin
      nxt_q    <= nxt_c;
      prv_q    <= prv_c;
      hd_hit_q <= (head_q == pos_q);
      tl_hit_q <= (tail_q == pos_q);
    end
    if (cmd_i.step) begin
      walk_q <= nxa_val;
      k_q    <= k_q + alm_pkg::slot_t'(1);
    end
    if (cmd_i.fin) begin
      out_slot_q  <= (is_loc && st_q == alm_pkg::StOk) ? walk_q : res_slot_q;
      out_st_q    <= st_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_o          = out_slot_q;
  assign status_o        = out_st_q;
  assign element_count_o = out_count_q;

endmodule

// ===== tb/alm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_checker
// Watches both channels of the list manager, keeps its own copy of the slot
// store and links, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module alm_checker
  import alm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         mode_i,
  input  slot_t              position_i,
  input  logic [ValueW-1:0]  item_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  slot_t              slot_i,
  input  logic [1:0]         status_i,
  input  slot_t              element_count_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);

  typedef struct packed {
    slot_t   slot;
    status_e status;
    slot_t   count;
  } list_result_t;

  list_result_t result_q[$];

  slot_t link_nx [Slots];
  slot_t link_pv [Slots];
  bit    is_free [Slots];
  slot_t head_r, tail_r, free_r, count_r;

  task automatic clear_list();
    for (int i = 0; i < Slots; i++) begin
      link_nx[i] = (i == 0 || i == Slots - 1) ? slot_t'(0) : slot_t'(i + 1);
      link_pv[i] = '0;
      is_free[i] = (i != 0);
    end
    head_r  = '0;
    tail_r  = '0;
    free_r  = slot_t'(1);
    count_r = '0;
  endtask

  function automatic bit anchor_ok(slot_t p);
    if (p == 0) return count_r == 0;
    return !is_free[p];
  endfunction

  // Take the free-list head and link it between pv and nx.
  task automatic splice(input slot_t nx, input slot_t pv,
                        output slot_t s, output status_e st);
    slot_t ins;
    ins = free_r;
    if (ins == 0) begin
      s  = '0;
      st = StFull;
    end else begin
      free_r       = link_nx[ins];
      link_nx[ins] = nx;
      link_pv[ins] = pv;
      is_free[ins] = 1'b0;
      if (pv == 0) head_r = ins;
      else link_nx[pv] = ins;
      if (nx == 0) tail_r = ins;
      else link_pv[nx] = ins;
      count_r++;
      s  = ins;
      st = StOk;
    end
  endtask

  task automatic insert_rel(input bit after, input slot_t p,
                            output slot_t s, output status_e st);
    if (!anchor_ok(p)) begin
      s  = '0;
      st = StBad;
    end else if (after) begin
      splice((p == 0) ? slot_t'(0) : link_nx[p], p, s, st);
    end else begin
      splice(p, (p == 0) ? slot_t'(0) : link_pv[p], s, st);
    end
  endtask

  task automatic unlink(input slot_t p, output slot_t s, output status_e st);
    slot_t nx, pv;
    if (p == 0 || is_free[p]) begin
      s  = '0;
      st = StBad;
    end else begin
      nx = link_nx[p];
      pv = link_pv[p];
      if (head_r == p) head_r = nx;
      else if (pv != 0) link_nx[pv] = nx;
      if (tail_r == p) tail_r = pv;
      else if (nx != 0) link_pv[nx] = pv;
      link_pv[p] = '0;
      is_free[p] = 1'b1;
      link_nx[p] = free_r;
      free_r     = p;
      count_r--;
      s  = p;
      st = StOk;
    end
  endtask

  task automatic predict_request(input mode_t m, input slot_t p,
                                 output list_result_t r);
    slot_t   s;
    status_e st;
    s  = '0;
    st = StBad;
    case (m)
      ModeAfter:  insert_rel(1'b1, p, s, st);
      ModeBefore: insert_rel(1'b0, p, s, st);
      ModeFront:  insert_rel(1'b0, head_r, s, st);
      ModeBack:   insert_rel(1'b1, tail_r, s, st);
      ModeDelete: unlink(p, s, st);
      ModeLocate: begin
        if (p != 0 && p <= count_r) begin
          s = head_r;
          for (int i = 1; i < p; i++) s = link_nx[s];
          st = StOk;
        end
      end
      default: ;
    endcase
    r.slot   = s;
    r.status = st;
    r.count  = count_r;
  endtask

  initial begin
    clear_list();
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want, got;
    if (!rst_ni) begin
      clear_list();
      result_q.delete();
      outstanding_o = 0;
    end else begin
      // Results leave before a new request is predicted; no result can belong
      // to a request accepted at the same edge.
      if (out_valid_i && !out_stall_i) begin
        got.slot   = slot_i;
        got.status = status_e'(status_i);
        got.count  = element_count_i;
        if (result_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("Unexpected result slot=%0d status=%0d count=%0d",
                     got.slot, got.status, got.count);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch: expected slot=%0d status=%0d count=%0d, got slot=%0d status=%0d count=%0d",
                       want.slot, want.status, want.count,
                       got.slot, status_i, got.count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(mode_i, position_i, want);
        result_q.push_back(want);
      end
      outstanding_o = result_q.size();
    end
  end

endmodule

// ===== tb/tb_array_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_manager_core
// Drives directed and phased random list requests into the manager with random
// gaps and output stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_array_linked_list_manager_core;
  import alm_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        mode_i;
  slot_t             position_i;
  logic [ValueW-1:0] item_value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  slot_t             slot_o;
  logic [1:0]        status_o;
  slot_t             element_count_o;

  int fail_count;
  int outstanding;

  // While quiet is set neither side idles.
  bit quiet;
  int stall_left;

  // Stimulus side view of the list, learned from the results. It only steers
  // the choice of positions; the checker does the real prediction.
  bit    live [Slots];
  mode_t sent_q[$];
  slot_t last_count;

  array_linked_list_manager_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .element_count_o(element_count_o)
  );

  alm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .slot_i         (slot_o),
    .status_i       (status_o),
    .element_count_i(element_count_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // The receiving side stalls in stretches chosen the same way.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left  <= gap_len();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Track which slots are in use from the results that come back.
  always @(posedge clk_i) begin
    mode_t m;
    if (rst_ni && out_valid_o && !out_stall_i && sent_q.size() != 0) begin
      m = sent_q.pop_front();
      last_count = element_count_o;
      if (status_o == StOk) begin
        if (m == ModeDelete) live[slot_o] = 1'b0;
        else if (m != ModeLocate) live[slot_o] = 1'b1;
      end
    end
  end

  // Present one request and wait until it is taken. The caller is at a
  // rising edge; valid stays high if the next request follows at once.
  task automatic send(input mode_t m, input slot_t p, input logic [ValueW-1:0] v);
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    position_i   <= p;
    item_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sent_q.push_back(m);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Mostly a slot that is in the list, sometimes any index at all.
  function automatic slot_t pick_slot();
    slot_t s;
    if ($urandom_range(0, 9) < 8) begin
      for (int t = 0; t < 40; t++) begin
        s = slot_t'($urandom_range(1, Slots - 1));
        if (live[s]) return s;
      end
    end
    return slot_t'($urandom_range(0, Slots - 1));
  endfunction

  initial begin : timeout
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int    r, phase, ins_pct;
    mode_t m;
    slot_t p;
    in_valid_i   = 1'b0;
    mode_i       = '0;
    position_i   = '0;
    item_value_i = '0;
    out_stall_i  = 1'b0;
    stall_left   = 0;
    quiet        = 1'b0;
    last_count   = '0;
    for (int i = 0; i < Slots; i++) live[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, sentinel anchor, refusals, extremes.
    send(ModeLocate, 8'd0, '0);
    send(ModeLocate, 8'd1, '0);
    send(ModeDelete, 8'd0, '0);
    send(ModeDelete, 8'd255, '0);
    send(ModeAfter, 8'd7, 32'hFFFF_FFFF);       // anchor is a free slot
    send(ModeBefore, 8'd0, 32'h0000_0000);      // sentinel on an empty list
    send(ModeAfter, 8'd0, 32'hFFFF_FFFF);       // sentinel on a non-empty list
    send(ModeBefore, 8'd0, 32'h1234_5678);
    send(ModeFront, 8'd200, 32'hA5A5_A5A5);
    send(ModeBack, 8'd255, 32'h5A5A_5A5A);
    send(ModeAfter, 8'd1, 32'h0000_0001);
    send(ModeBefore, 8'd1, 32'h8000_0000);
    send(3'd6, 8'd1, '0);
    send(3'd7, 8'd255, 32'hFFFF_FFFF);
    send(ModeLocate, 8'd1, '0);
    send(ModeLocate, 8'd5, '0);
    send(ModeLocate, 8'd6, '0);
    send(ModeLocate, 8'd255, '0);
    send(ModeDelete, 8'd1, '0);
    send(ModeDelete, 8'd1, '0);                 // already free
    send(ModeBefore, 8'd1, '0);                 // relative to a freed slot
    send(ModeFront, 8'd0, '0);
    pause(gap_len());

    // Random phases: fill the store, stress the full store,
    // drain, then mixed traffic with and without idling.
    for (int n = 0; n < 1750; n++) begin
      phase = n / 350;
      case (phase)
        0: ins_pct = 92;
        1: ins_pct = 60;
        2: ins_pct = 15;
        default: ins_pct = 45;
      endcase
      quiet = (phase == 3);
      if (n == 875) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 3) m = mode_t'($urandom_range(6, 7));
      else if (r < 10) m = ModeLocate;
      else if ($urandom_range(0, 99) < ins_pct) m = mode_t'($urandom_range(0, 3));
      else m = ModeDelete;
      if (m == ModeLocate) begin
        p = ($urandom_range(0, 9) == 0) ? slot_t'($urandom_range(0, Slots - 1))
                                        : slot_t'($urandom_range(0, last_count + 1));
      end else if ($urandom_range(0, 19) == 0) begin
        p = '0;
      end else begin
        p = pick_slot();
      end
      send(m, p, $urandom);
      if (!quiet) pause(gap_len());
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== array_linked_list_manager_core.f =====
src/alm_pkg.sv
src/alm_ctrl.sv
src/alm_dpath.sv
src/array_linked_list_manager_core.sv
tb/alm_checker.sv
tb/tb_array_linked_list_manager_core.sv
